FILE: sv/pcot_pkg.sv
// Shared widths, register codes, reset values and control types of the offset tracker.
`default_nettype none

package pcot_pkg;

	localparam int PEER_W  = 4;
	localparam int TS_W    = 32;
	localparam int OWN_W   = 4;
	localparam int THR_W   = 31;
	localparam int MASK_W  = 8;
	localparam int CFG_W   = 31;
	localparam int REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_OWN_PLAYER   = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_RTT_THRESHOLD = 1'd1;

	localparam logic [OWN_W-1:0] OWN_RESET = 4'd1;
	localparam logic [THR_W-1:0] THR_RESET = 31'd100;
	localparam logic [TS_W-1:0]  RTT_RESET = 32'h7FFF_FFFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // sample beat taken: register the raw differences
		logic evaluate;  // form round trip and offset, read the stored entry
		logic commit;    // update the table and load the result register
	} cmd_t;

endpackage

`default_nettype wire

FILE: sv/pcot_if.sv
// Sample and result channel interfaces of the offset tracker.
`default_nettype none

interface pcot_sample_if;
	logic                         valid;
	logic                         ready;
	logic [pcot_pkg::PEER_W-1:0]  peer_number;
	logic [pcot_pkg::TS_W-1:0]    request_sent_time;
	logic [pcot_pkg::TS_W-1:0]    request_received_time;
	logic [pcot_pkg::TS_W-1:0]    response_sent_time;
	logic [pcot_pkg::TS_W-1:0]    response_received_time;

	modport source (output valid, peer_number, request_sent_time, request_received_time,
		response_sent_time, response_received_time, input ready);
	modport sink (input valid, peer_number, request_sent_time, request_received_time,
		response_sent_time, response_received_time, output ready);
endinterface

interface pcot_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [pcot_pkg::TS_W-1:0]  best_round_trip;
	logic signed [pcot_pkg::TS_W-1:0]  best_offset;
	logic                              entry_replaced;
	logic [pcot_pkg::MASK_W-1:0]       request_mask;

	modport source (output valid, best_round_trip, best_offset, entry_replaced,
		request_mask, input ready);
	modport sink (input valid, best_round_trip, best_offset, entry_replaced,
		request_mask, output ready);
endinterface

`default_nettype wire

FILE: sv/peer_clock_offset_tracker.sv
// Top level of the per-peer round-trip and clock offset tracker.
//
//   channel   direction  handshake      payload
//   sample    in         valid/ready    peer number, four 32-bit timestamps
//   result    out        valid/ready    best rtt, best offset, replaced flag, request mask
//   config    in         write_enable   reg_index, write_data (no read-back)
//
// A sample passes through three steps: capture of the timestamp differences, the
// round-trip/offset arithmetic with the table read, then the table update.
// The table is a read-modify-write per sample, so one sample is in flight.
// A stalled result holds the update stage; the next sample is taken while a
// finished result waits. Reset loads the table, config registers and FSM at once.
`default_nettype none

module peer_clock_offset_tracker #(
	parameter int MAX_PEERS = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            write_enable,
	input  wire logic [pcot_pkg::REG_IDX_W-1:0]  reg_index,
	input  wire logic [pcot_pkg::CFG_W-1:0]      write_data,
	pcot_sample_if.sink                          sample,
	pcot_result_if.source                        result
);

	pcot_pkg::cmd_t cmd;

	pcot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	pcot_dp #(
		.MAX_PEERS (MAX_PEERS)
	) u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.write_enable           (write_enable),
		.reg_index              (reg_index),
		.write_data             (write_data),
		.peer_number            (sample.peer_number),
		.request_sent_time      (sample.request_sent_time),
		.request_received_time  (sample.request_received_time),
		.response_sent_time     (sample.response_sent_time),
		.response_received_time (sample.response_received_time),
		.best_round_trip        (result.best_round_trip),
		.best_offset            (result.best_offset),
		.entry_replaced         (result.entry_replaced),
		.request_mask           (result.request_mask)
	);

endmodule

`default_nettype wire

FILE: sv/pcot_ctrl.sv
// Controller state machine of the offset tracker.
`default_nettype none

module pcot_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output pcot_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_CALC   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// The result register may be refilled in the cycle its beat leaves.
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		cmd.capture  = 1'b0;
		cmd.evaluate = 1'b0;
		cmd.commit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.evaluate = 1'b1;
				state_d      = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: sv/pcot_dp.sv
// Datapath of the offset tracker: differences, per-peer table and result register.
`default_nettype none

module pcot_dp #(
	parameter int MAX_PEERS = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire pcot_pkg::cmd_t                     cmd,
	input  wire logic                               write_enable,
	input  wire logic [pcot_pkg::REG_IDX_W-1:0]     reg_index,
	input  wire logic [pcot_pkg::CFG_W-1:0]         write_data,
	input  wire logic [pcot_pkg::PEER_W-1:0]        peer_number,
	input  wire logic [pcot_pkg::TS_W-1:0]          request_sent_time,
	input  wire logic [pcot_pkg::TS_W-1:0]          request_received_time,
	input  wire logic [pcot_pkg::TS_W-1:0]          response_sent_time,
	input  wire logic [pcot_pkg::TS_W-1:0]          response_received_time,
	output logic signed [pcot_pkg::TS_W-1:0]        best_round_trip,
	output logic signed [pcot_pkg::TS_W-1:0]        best_offset,
	output logic                                    entry_replaced,
	output logic [pcot_pkg::MASK_W-1:0]             request_mask
);

	localparam int IDX_W    = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
	localparam int NUM_MASK = (MAX_PEERS < pcot_pkg::MASK_W) ? MAX_PEERS : pcot_pkg::MASK_W;
	localparam int PX_W     = 6;
	localparam int W        = pcot_pkg::TS_W;

	// Configuration registers.
	logic [pcot_pkg::OWN_W-1:0] own_q;
	logic [pcot_pkg::THR_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= pcot_pkg::OWN_RESET;
			thr_q <= pcot_pkg::THR_RESET;
		end else if (write_enable) begin
			case (reg_index)
				pcot_pkg::REG_OWN_PLAYER:    own_q <= write_data[pcot_pkg::OWN_W-1:0];
				pcot_pkg::REG_RTT_THRESHOLD: thr_q <= write_data[pcot_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: the four timestamp differences, all independent.
	logic [PX_W-1:0]  peer_ext;
	logic             in_range;
	logic [W-1:0]     fwd_s1, turn_s1, up_s1, down_s1;
	logic             ok_s1;
	logic [IDX_W-1:0] idx_s1;

	assign peer_ext = {{(PX_W-pcot_pkg::PEER_W){1'b0}}, peer_number};
	assign in_range = (peer_ext != '0) && (peer_ext <= PX_W'(MAX_PEERS));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			fwd_s1  <= response_received_time - request_sent_time;
			turn_s1 <= response_sent_time - request_received_time;
			up_s1   <= request_received_time - request_sent_time;
			down_s1 <= response_sent_time - response_received_time;
			ok_s1   <= in_range;
			idx_s1  <= IDX_W'(peer_ext - PX_W'(1));
		end
	end

	// Stage 2: round trip, halved offset and the stored entry of this peer.
	logic [W-1:0]        rtt_tab_q [MAX_PEERS];
	logic [W-1:0]        off_tab_q [MAX_PEERS];
	logic signed [W:0]   sum;
	logic signed [W:0]   sum_adj;
	logic [W-1:0]        rtt_s2, off_s2, old_rtt_s2, old_off_s2;
	logic                ok_s2;
	logic [IDX_W-1:0]    idx_s2;

	assign sum = $signed({up_s1[W-1], up_s1}) + $signed({down_s1[W-1], down_s1});
	// Adding the sign bit before the arithmetic shift rounds toward zero.
	assign sum_adj = sum + $signed({{W{1'b0}}, sum[W]});

	always_ff @(posedge clk) begin
		if (cmd.evaluate) begin
			rtt_s2     <= fwd_s1 - turn_s1;
			off_s2     <= sum_adj[W:1];
			old_rtt_s2 <= rtt_tab_q[idx_s1];
			old_off_s2 <= off_tab_q[idx_s1];
			ok_s2      <= ok_s1;
			idx_s2     <= idx_s1;
		end
	end

	// Commit: |old - new| > stored rtt is tested as two signed compares.
	logic signed [W+1:0] diff;
	logic signed [W+1:0] ref_rtt;
	logic                lower;
	logic                moved;
	logic                replace;

	assign diff    = $signed({{2{old_off_s2[W-1]}}, old_off_s2})
	               - $signed({{2{off_s2[W-1]}}, off_s2});
	assign ref_rtt = $signed({{2{old_rtt_s2[W-1]}}, old_rtt_s2});
	assign lower   = $signed(rtt_s2) < $signed(old_rtt_s2);
	assign moved   = (diff > ref_rtt) || ((diff + ref_rtt) < $signed((W+2)'(0)));
	assign replace = ok_s2 && (lower || moved);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PEERS; i++) begin
				rtt_tab_q[i] <= pcot_pkg::RTT_RESET;
				off_tab_q[i] <= '0;
			end
		end else if (cmd.commit && replace) begin
			rtt_tab_q[idx_s2] <= rtt_s2;
			off_tab_q[idx_s2] <= off_s2;
		end
	end

	// The mask sees the table as it stands after this commit.
	logic [pcot_pkg::MASK_W-1:0] mask_d;
	logic [W-1:0]                rtt_next;

	always_comb begin
		mask_d   = '0;
		rtt_next = '0;
		for (int p = 0; p < NUM_MASK; p++) begin
			rtt_next = (replace && (idx_s2 == IDX_W'(p))) ? rtt_s2 : rtt_tab_q[p];
			if (({1'b0, own_q} != 5'(p + 1))
					&& ($signed(rtt_next) > $signed({1'b0, thr_q}))) begin
				mask_d[p] = 1'b1;
			end
		end
	end

	logic [W-1:0]                rtt_q, off_q;
	logic                        repl_q;
	logic [pcot_pkg::MASK_W-1:0] mask_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rtt_q  <= !ok_s2 ? '0 : (replace ? rtt_s2 : old_rtt_s2);
			off_q  <= !ok_s2 ? '0 : (replace ? off_s2 : old_off_s2);
			repl_q <= replace;
			mask_q <= mask_d;
		end
	end

	assign best_round_trip = $signed(rtt_q);
	assign best_offset     = $signed(off_q);
	assign entry_replaced  = repl_q;
	assign request_mask    = mask_q;

endmodule

`default_nettype wire

FILE: sv/pcot_chk.sv
// Port-level checker of the offset tracker and its bind.
`default_nettype none

module pcot_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready
);

	// A result beat waits until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before it was taken");

	// After a sample beat, ready stays low through the calculation and update states.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("sample taken while the previous one is in flight");

	// Ready returns once the sample has been committed.
	a_ready_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready |=> ##1 in_ready)
		else $error("sample channel not released after commit");

	// A fresh result rises only for a sample beat that passed calculation and update without a stall.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 3))
		else $error("result appeared without a matching sample");

endmodule

bind peer_clock_offset_tracker pcot_chk u_pcot_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready)
);

`default_nettype wire
